>>> rtl/periodic_task_scheduler_assert.svh
// Assertion macros for the periodic task scheduler.
`ifndef PERIODIC_TASK_SCHEDULER_ASSERT_SVH
`define PERIODIC_TASK_SCHEDULER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PTS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pts_pkg.sv
// Shared types and codes of the periodic task scheduler.
package pts_pkg;

  localparam logic [2:0] CmdRegister = 3'd0;
  localparam logic [2:0] CmdCancel   = 3'd1;
  localparam logic [2:0] CmdTick     = 3'd2;
  localparam logic [2:0] CmdCheck    = 3'd3;
  localparam logic [2:0] CmdDispatch = 3'd4;

  localparam logic [1:0] KindStatus = 2'd0;
  localparam logic [1:0] KindSlot   = 2'd1;
  localparam logic [1:0] KindNone   = 2'd2;

  typedef enum logic [2:0] {
    OpRegister,
    OpCancel,
    OpTick,
    OpCheck,
    OpDispatch,
    OpUnknown
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       index_ok;
    logic [2:0] task_index;
    logic [7:0] period;
    logic       handler_valid;
  } cmd_t;

endpackage

>>> rtl/pts_front.sv
// Front end: input handshake and command classification.
module pts_front import pts_pkg::*; #(
  parameter int TASK_SLOTS = 8
) (
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] command_i,
  input  logic [2:0] task_index_i,
  input  logic [7:0] period_i,
  input  logic       handler_valid_i,
  input  logic       full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  localparam logic [6:0] SlotLimit = 7'(TASK_SLOTS);

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    cmd_o.index_ok      = {4'b0000, task_index_i} < SlotLimit;
    cmd_o.task_index    = task_index_i;
    cmd_o.period        = period_i;
    cmd_o.handler_valid = handler_valid_i;
    unique case (command_i)
      CmdRegister: cmd_o.op = OpRegister;
      CmdCancel:   cmd_o.op = OpCancel;
      CmdTick:     cmd_o.op = OpTick;
      CmdCheck:    cmd_o.op = OpCheck;
      CmdDispatch: cmd_o.op = OpDispatch;
      default:     cmd_o.op = OpUnknown;
    endcase
  end

endmodule

>>> rtl/pts_fifo.sv
// Two-entry command queue between the front end and the back end.
module pts_fifo import pts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output cmd_t data_o,
  output logic full_o,
  output logic empty_o
);

  logic [1:0] cnt_q, cnt_d;
  logic       wr_q, rd_q;
  cmd_t       mem_q [2];

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_q];
  assign cnt_d   = cnt_q + {1'b0, push_i} - {1'b0, pop_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

>>> rtl/pts_back.sv
// Back end: task table, command execution and result register.
module pts_back import pts_pkg::*; #(
  parameter int TASK_SLOTS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  cmd_t       cmd_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] result_kind_o,
  output logic       success_o,
  output logic [2:0] slot_out_o,
  output logic       last_o
);

  // Only slots 0 to 7 can be addressed, so no more are built.
  localparam int NumSlots = (TASK_SLOTS < 8) ? TASK_SLOTS : 8;
  localparam int CntW = $clog2(NumSlots + 1);
  localparam logic [6:0] SlotLimit = 7'(TASK_SLOTS);

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  state_e              state_q, state_d;
  cmd_t                cur_q, cur_d;
  logic [NumSlots-1:0] reg_q, reg_d;
  logic [NumSlots-1:0] rdy_q, rdy_d;
  logic [7:0]          period_q [NumSlots];
  logic [7:0]          period_d [NumSlots];
  logic [7:0]          elapsed_q [NumSlots];
  logic [7:0]          elapsed_d [NumSlots];
  logic [CntW-1:0]     count_q, count_d;
  logic                out_valid_q, out_valid_d;
  logic [1:0]          kind_q, kind_d;
  logic                success_q, success_d;
  logic [2:0]          slot_q, slot_d;
  logic                last_q, last_d;

  logic [NumSlots-1:0] sel;
  logic [NumSlots-1:0] pend;
  logic [NumSlots-1:0] lowest;
  logic [NumSlots-1:0] rest;
  logic [2:0]          lowest_idx;
  logic                hit_reg;
  logic                can_emit;

  always_comb begin
    lowest_idx = 3'd0;
    for (int i = 0; i < NumSlots; i++) begin
      sel[i] = cur_q.task_index == 3'(i);
    end
    hit_reg = |(reg_q & sel);
    pend    = reg_q & rdy_q;
    lowest  = pend & (~pend + NumSlots'(1));
    rest    = pend & ~lowest;
    for (int i = 0; i < NumSlots; i++) begin
      if (lowest[i]) begin
        lowest_idx = lowest_idx | 3'(i);
      end
    end
  end

  assign can_emit = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    reg_d       = reg_q;
    rdy_d       = rdy_q;
    period_d    = period_q;
    elapsed_d   = elapsed_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    success_d   = success_q;
    slot_d      = slot_q;
    last_d      = last_q;
    pop_o       = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          cur_d   = cmd_i;
          state_d = StRun;
        end
      end
      StRun: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          kind_d      = KindStatus;
          success_d   = 1'b0;
          slot_d      = 3'd0;
          last_d      = 1'b1;
          state_d     = StIdle;
          unique case (cur_q.op)
            OpRegister: begin
              if (cur_q.index_ok && cur_q.handler_valid && !hit_reg &&
                  (7'(count_q) < SlotLimit)) begin
                success_d = 1'b1;
                count_d   = count_q + CntW'(1);
                for (int i = 0; i < NumSlots; i++) begin
                  if (sel[i]) begin
                    reg_d[i]     = 1'b1;
                    rdy_d[i]     = 1'b0;
                    period_d[i]  = cur_q.period;
                    elapsed_d[i] = 8'd0;
                  end
                end
              end
            end
            OpCancel: begin
              if (cur_q.index_ok && hit_reg && (count_q != '0)) begin
                success_d = 1'b1;
                count_d   = count_q - CntW'(1);
                for (int i = 0; i < NumSlots; i++) begin
                  if (sel[i]) begin
                    reg_d[i]     = 1'b0;
                    rdy_d[i]     = 1'b0;
                    period_d[i]  = 8'd0;
                    elapsed_d[i] = 8'd0;
                  end
                end
              end
            end
            OpTick: begin
              success_d = 1'b1;
              for (int i = 0; i < NumSlots; i++) begin
                if (reg_q[i] && (elapsed_q[i] != 8'hFF)) begin
                  elapsed_d[i] = elapsed_q[i] + 8'd1;
                end
              end
            end
            OpCheck: begin
              success_d = 1'b1;
              for (int i = 0; i < NumSlots; i++) begin
                if (reg_q[i] && (elapsed_q[i] >= period_q[i])) begin
                  elapsed_d[i] = 8'd0;
                  rdy_d[i]     = 1'b1;
                end
              end
            end
            OpDispatch: begin
              if (pend == '0) begin
                kind_d = KindNone;
              end else begin
                kind_d    = KindSlot;
                success_d = 1'b1;
                slot_d    = lowest_idx;
                last_d    = rest == '0;
                rdy_d     = rdy_q & ~lowest;
                if (rest != '0) begin
                  state_d = StRun;
                end
              end
            end
            OpUnknown: begin
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cur_q       <= '0;
      reg_q       <= '0;
      rdy_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= KindStatus;
      success_q   <= 1'b0;
      slot_q      <= 3'd0;
      last_q      <= 1'b0;
      for (int i = 0; i < NumSlots; i++) begin
        period_q[i]  <= 8'd0;
        elapsed_q[i] <= 8'd0;
      end
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      reg_q       <= reg_d;
      rdy_q       <= rdy_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      kind_q      <= kind_d;
      success_q   <= success_d;
      slot_q      <= slot_d;
      last_q      <= last_d;
      period_q    <= period_d;
      elapsed_q   <= elapsed_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign success_o     = success_q;
  assign slot_out_o    = slot_q;
  assign last_o        = last_q;

endmodule

>>> rtl/periodic_task_scheduler.sv
// Top level of the periodic task scheduler.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_ready_o   command, task_index, period, handler_valid
//   out      output     out_valid_o/out_ready_i result_kind, success, slot_out, last
//
// A queued command is popped into the command register and executes in the run state.
// Results wait in the run state until the output can take them.
// A dispatch emits one result per ready slot, lowest first, or a single empty result.
// The two-entry queue keeps accepting transactions while a result waits, until full.
// Reset clears the whole task table at once; there is no clearing pass.
`include "periodic_task_scheduler_assert.svh"

module periodic_task_scheduler import pts_pkg::*; #(
  parameter int TASK_SLOTS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] command_i,
  input  logic [2:0] task_index_i,
  input  logic [7:0] period_i,
  input  logic       handler_valid_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] result_kind_o,
  output logic       success_o,
  output logic [2:0] slot_out_o,
  output logic       last_o
);

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic push;
  logic pop;
  logic full;
  logic empty;

  pts_front #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .task_index_i   (task_index_i),
    .period_i       (period_i),
    .handler_valid_i(handler_valid_i),
    .full_i         (full),
    .push_o         (push),
    .cmd_o          (front_cmd)
  );

  pts_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_cmd),
    .pop_i  (pop),
    .data_o (queue_cmd),
    .full_o (full),
    .empty_o(empty)
  );

  pts_back #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .cmd_i        (queue_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_kind_o(result_kind_o),
    .success_o    (success_o),
    .slot_out_o   (slot_out_o),
    .last_o       (last_o)
  );

  `PTS_ASSERT_NOW(a_status_shape, out_valid_o && (result_kind_o == KindStatus), (slot_out_o == 3'd0) && last_o, "status result with slot or not last")
  `PTS_ASSERT_NOW(a_none_shape, out_valid_o && (result_kind_o == KindNone), last_o && !success_o && (slot_out_o == 3'd0), "malformed empty dispatch result")
  `PTS_ASSERT_NEXT(a_dispatch_order, out_valid_o && out_ready_i && (result_kind_o == KindSlot) && !last_o, out_valid_o && (result_kind_o == KindSlot) && (slot_out_o > $past(slot_out_o)), "dispatch burst broken or out of order")

endmodule
